/* sv/cacn_pkg.sv */
// Shared types, constants and reset values for the color attention change notifier.
package cacn_pkg;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned SlotIdxW  = 3;
  localparam int unsigned SlotW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [TimeW-1:0]  RstSyncWindow  = 32'd1000;
  localparam logic [ColorW-1:0] RstColorOff    = 24'h000000;
  localparam logic [ColorW-1:0] RstColorWork   = 24'h304FFE;
  localparam logic [ColorW-1:0] RstColorUnread = 24'h00FF4C;
  localparam logic [ColorW-1:0] RstColorAction = 24'hFF6D00;
  localparam logic [ColorW-1:0] RstColorError  = 24'hFF0033;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_UNREAD = 2'd1,
    CLS_ACTION = 2'd2,
    CLS_ERROR  = 2'd3
  } class_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_WINDOW = 3'd0,
    CFG_COLOR_OFF   = 3'd1,
    CFG_COLOR_WORK  = 3'd2,
    CFG_COLOR_UNRD  = 3'd3,
    CFG_COLOR_ACT   = 3'd4,
    CFG_COLOR_ERR   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0]  sync_window_ms;
    logic [ColorW-1:0] color_off;
    logic [ColorW-1:0] color_working;
    logic [ColorW-1:0] color_unread;
    logic [ColorW-1:0] color_action;
    logic [ColorW-1:0] color_error;
  } cfg_t;

endpackage

/* sv/cacn_if.sv */
// Valid/ready channel interfaces for observations and attention events.
interface cacn_obs_if;
  logic                           valid;
  logic                           ready;
  logic [cacn_pkg::SlotIdxW-1:0]  slot_index;
  logic [cacn_pkg::ColorW-1:0]    color_rgb;
  logic [cacn_pkg::TimeW-1:0]     time_ms;

  modport source (output valid, slot_index, color_rgb, time_ms, input ready);
  modport sink   (input valid, slot_index, color_rgb, time_ms, output ready);
endinterface

interface cacn_evt_if;
  logic                  valid;
  logic                  ready;
  cacn_pkg::class_e      attention_event;

  modport source (output valid, attention_event, input ready);
  modport sink   (input valid, attention_event, output ready);
endinterface

/* sv/color_attention_change_notifier_core.sv */
// Top level: input register, tracker, result register and configuration port.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------
//  obs_i   | in  | valid/ready         | slot_index, color_rgb, time_ms
//  evt_o   | out | valid/ready         | attention_event
//  cfg     | in  | cfg_we_i, no ready  | cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle sustained while evt_o is taken; each item passes
// through the input register, then the result register.
// Slot state updates when an item moves from the input register into the
// result register, so items are applied strictly in arrival order.
// Reset (rst_ni low, async) clears valids, slot state and loads config defaults.
// A stalled result holds the input register; obs_i.ready drops only when both
// registers are full and evt_o is not taken.
module color_attention_change_notifier_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cacn_obs_if.sink                       obs_i,
  cacn_evt_if.source                     evt_o,
  input  logic                           cfg_we_i,
  input  logic [cacn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cacn_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  cacn_pkg::cfg_t cfg;

  // input register
  logic                           s1_vld_q, s1_vld_d;
  logic [cacn_pkg::SlotIdxW-1:0]  s1_slot_q;
  logic [cacn_pkg::ColorW-1:0]    s1_rgb_q;
  logic [cacn_pkg::TimeW-1:0]     s1_time_q;

  // result register
  logic                           out_vld_q, out_vld_d;
  cacn_pkg::class_e               out_evt_q;
  cacn_pkg::class_e               evt_next;

  logic out_free;
  logic adv;
  logic accept;

  cacn_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cacn_tracker u_trk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .cfg_i        (cfg),
    .slot_index_i (s1_slot_q),
    .color_rgb_i  (s1_rgb_q),
    .time_ms_i    (s1_time_q),
    .event_o      (evt_next)
  );

  // result slot frees up when empty or taken this cycle
  assign out_free    = !out_vld_q || evt_o.ready;
  assign adv         = s1_vld_q && out_free;
  assign obs_i.ready = !s1_vld_q || adv;
  assign accept      = obs_i.valid && obs_i.ready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept)   s1_vld_d = 1'b1;
    else if (adv) s1_vld_d = 1'b0;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv)              out_vld_d = 1'b1;
    else if (evt_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_slot_q <= obs_i.slot_index;
      s1_rgb_q  <= obs_i.color_rgb;
      s1_time_q <= obs_i.time_ms;
    end
    if (adv) out_evt_q <= evt_next;
  end

  assign evt_o.valid           = out_vld_q;
  assign evt_o.attention_event = out_evt_q;

`ifndef SYNTHESIS
  // both stages full and result stalled: no new transaction taken
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !evt_o.ready) |-> !obs_i.ready)
    else $error("input accepted while pipeline full");
  // accepted transaction lands in the input register
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted transaction lost");
  // every advance produces a result next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced item produced no result");
`endif

endmodule

/* sv/cacn_cfg_regs.sv */
// Configuration register file: window length and color words.
module cacn_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cacn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cacn_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output cacn_pkg::cfg_t                 cfg_o
);

  cacn_pkg::cfg_t cfg_q, cfg_d;
  logic [cacn_pkg::ColorW-1:0] wcolor;

  assign wcolor = cfg_wdata_i[cacn_pkg::ColorW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cacn_pkg::cfg_idx_e'(cfg_idx_i))
        cacn_pkg::CFG_SYNC_WINDOW: cfg_d.sync_window_ms = cfg_wdata_i[cacn_pkg::TimeW-1:0];
        cacn_pkg::CFG_COLOR_OFF:   cfg_d.color_off      = wcolor;
        cacn_pkg::CFG_COLOR_WORK:  cfg_d.color_working  = wcolor;
        cacn_pkg::CFG_COLOR_UNRD:  cfg_d.color_unread   = wcolor;
        cacn_pkg::CFG_COLOR_ACT:   cfg_d.color_action   = wcolor;
        cacn_pkg::CFG_COLOR_ERR:   cfg_d.color_error    = wcolor;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_window_ms <= cacn_pkg::RstSyncWindow;
      cfg_q.color_off      <= cacn_pkg::RstColorOff;
      cfg_q.color_working  <= cacn_pkg::RstColorWork;
      cfg_q.color_unread   <= cacn_pkg::RstColorUnread;
      cfg_q.color_action   <= cacn_pkg::RstColorAction;
      cfg_q.color_error    <= cacn_pkg::RstColorError;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/cacn_tracker.sv */
// Slot state (per-slot seen mask and last class, one shared sync start) and the event decision.
module cacn_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  cacn_pkg::cfg_t                 cfg_i,
  input  logic [cacn_pkg::SlotIdxW-1:0]  slot_index_i,
  input  logic [cacn_pkg::ColorW-1:0]    color_rgb_i,
  input  logic [cacn_pkg::TimeW-1:0]     time_ms_i,
  output cacn_pkg::class_e               event_o
);

  logic [cacn_pkg::SLOTS-1:0]  seen_q, seen_d;
  logic [cacn_pkg::TimeW-1:0]  sync_start_q, sync_start_d;
  cacn_pkg::class_e            last_q [cacn_pkg::SLOTS];
  cacn_pkg::class_e            last_wr;
  logic                        last_we;

  logic                        in_range;
  logic [cacn_pkg::SlotW-1:0]  idx;
  logic [cacn_pkg::SLOTS-1:0]  slot_bit;
  logic [cacn_pkg::TimeW-1:0]  start_eff;
  logic [cacn_pkg::TimeW-1:0]  delta;
  logic                        in_window;
  cacn_pkg::class_e            cls;
  cacn_pkg::class_e            evt;

  assign in_range  = ({1'b0, slot_index_i} < (cacn_pkg::SlotIdxW+1)'(cacn_pkg::SLOTS));
  assign idx       = slot_index_i[cacn_pkg::SlotW-1:0];
  assign slot_bit  = cacn_pkg::SLOTS'(1) << idx;
  // empty mask: this observation opens the sync window
  assign start_eff = (seen_q == '0) ? time_ms_i : sync_start_q;
  assign delta     = time_ms_i - start_eff;
  assign in_window = (delta < cfg_i.sync_window_ms);

  // unread wins over action, action over error
  always_comb begin
    if (color_rgb_i == cfg_i.color_unread)      cls = cacn_pkg::CLS_UNREAD;
    else if (color_rgb_i == cfg_i.color_action) cls = cacn_pkg::CLS_ACTION;
    else if (color_rgb_i == cfg_i.color_error)  cls = cacn_pkg::CLS_ERROR;
    else                                        cls = cacn_pkg::CLS_NONE;
  end

  always_comb begin
    seen_d       = seen_q;
    sync_start_d = sync_start_q;
    last_we      = 1'b0;
    last_wr      = cacn_pkg::CLS_NONE;
    evt          = cacn_pkg::CLS_NONE;
    if (in_range) begin
      sync_start_d = start_eff;
      if (((seen_q & slot_bit) == '0) || in_window) begin
        seen_d  = seen_q | slot_bit;
        last_we = 1'b1;
        last_wr = cls;
      end else if ((color_rgb_i == cfg_i.color_working) ||
                   (color_rgb_i == cfg_i.color_off)) begin
        last_we = 1'b1;
        last_wr = cacn_pkg::CLS_NONE;
      end else if ((cls != cacn_pkg::CLS_NONE) && (last_q[idx] != cls)) begin
        last_we = 1'b1;
        last_wr = cls;
        evt     = cls;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= '0;
      sync_start_q <= '0;
      for (int i = 0; i < cacn_pkg::SLOTS; i++) last_q[i] <= cacn_pkg::CLS_NONE;
    end else if (en_i) begin
      seen_q       <= seen_d;
      sync_start_q <= sync_start_d;
      if (last_we) last_q[idx] <= last_wr;
    end
  end

  assign event_o = evt;

`ifndef SYNTHESIS
  // an event is only raised for a slot that was already seen
  a_evt_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && evt != cacn_pkg::CLS_NONE) |-> ((seen_q & slot_bit) != '0))
    else $error("event raised for unseen slot");
  // a raised event is stored as the slot's new class
  a_evt_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && evt != cacn_pkg::CLS_NONE) |=> (last_q[$past(idx)] == $past(evt)))
    else $error("raised event not recorded");
  // a slot past the slot count never raises an event
  a_evt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !in_range) |-> (evt == cacn_pkg::CLS_NONE))
    else $error("event raised for out-of-range slot");
`endif

endmodule
